[sv/rkt_pkg.sv]
// rkt_pkg: shared types and codes for the recent key table
// no dependencies; used by the compare unit and the top level
package rkt_pkg;

	localparam int CALL_BYTES = 15;
	localparam int BAND_BYTES = 7;
	localparam int CALL_W     = 8 * CALL_BYTES;
	localparam int BAND_W     = 8 * BAND_BYTES;

	// action codes
	localparam logic [1:0] ACT_NOTE  = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_EPOCH_MIN = 2'd0;
	localparam logic [1:0] CFG_GRACE     = 2'd1;

	localparam logic [62:0] EPOCH_MIN_RST = 63'd1600000000;
	localparam logic [31:0] GRACE_RST     = 32'd600;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] call_high;
		logic [55:0] call_low;
		logic [55:0] band_code;
		logic [63:0] now_time;
	} rkt_in_t;

	typedef struct packed {
		logic worked_hit;
	} rkt_out_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [63:0] value;
	} rkt_cfg_t;

	typedef struct packed {
		logic [63:0] call_high;
		logic [55:0] call_low;
		logic [55:0] band;
	} rkt_key_t;

	typedef struct packed {
		rkt_key_t    key;
		logic [63:0] stamp;
	} rkt_entry_t;

	typedef struct packed {
		logic key_match;
		logic recent;
	} rkt_cmp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_FIN
	} rkt_state_t;

	// zero every byte after the first zero byte of the callsign
	function automatic logic [CALL_W-1:0] clean_call(logic [CALL_W-1:0] w);
		logic [CALL_W-1:0] r;
		logic              alive;
		r     = '0;
		alive = 1'b1;
		for (int k = 0; k < CALL_BYTES; k++) begin
			if (alive) begin
				r[CALL_W-1-8*k -: 8] = w[CALL_W-1-8*k -: 8];
			end
			if (w[CALL_W-1-8*k -: 8] == 8'd0) begin
				alive = 1'b0;
			end
		end
		return r;
	endfunction

	// same for the band name
	function automatic logic [BAND_W-1:0] clean_band(logic [BAND_W-1:0] w);
		logic [BAND_W-1:0] r;
		logic              alive;
		r     = '0;
		alive = 1'b1;
		for (int k = 0; k < BAND_BYTES; k++) begin
			if (alive) begin
				r[BAND_W-1-8*k -: 8] = w[BAND_W-1-8*k -: 8];
			end
			if (w[BAND_W-1-8*k -: 8] == 8'd0) begin
				alive = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

[sv/rkt_chan_if.sv]
// rkt_chan_if: valid/ready channel carrying one payload struct
// payload types come from rkt_pkg
interface rkt_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/rkt_ram.sv]
// rkt_ram: generic single-write, single-read memory with registered read data
// no package dependencies
module rkt_ram #(
	parameter int WIDTH = 240,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[sv/rkt_cmp_unit.sv]
// rkt_cmp_unit: shared key compare and age window check for one table entry
// depends on rkt_pkg
module rkt_cmp_unit (
	input  rkt_pkg::rkt_entry_t entry,
	input  logic                entry_valid,
	input  rkt_pkg::rkt_key_t   key,
	input  logic [63:0]         now_time,
	input  logic [31:0]         grace,
	output rkt_pkg::rkt_cmp_t   result
);
	logic [64:0] age;

	// exact signed difference, one bit wider so it cannot wrap
	assign age = {now_time[63], now_time} - {entry.stamp[63], entry.stamp};

	always_comb begin
		result.key_match = entry_valid && (entry.key == key);
		result.recent    = !age[64] && (age[63:32] == 32'd0) && (age[31:0] < grace);
	end
endmodule

[sv/recent_key_table_with_age_window.sv]
// recent_key_table_with_age_window: table of recently noted (callsign, band) keys
// depends on rkt_pkg, rkt_chan_if, rkt_ram, rkt_cmp_unit
//
// channel | dir | payload                                          | transaction
// req     | in  | action, call_high, call_low, band_code, now_time | valid & ready
// rsp     | out | worked_hit                                       | valid & ready
// cfg     | in  | index, value (0 epoch_minimum, 1 grace_seconds)  | valid & ready
//
// notes and queries scan the table: one entry read per cycle from the
// single read port of the entry memory, one compare stage, then write-back for notes
// clear, an unused action, an empty callsign or, for a query, an unset clock skip the scan
// reset clears the valid bits and the ring head and loads the config defaults at once
// req is taken only in idle; a held result in the output register does not block it,
// only the finish of the next item waits for rsp to drain
module recent_key_table_with_age_window #(
	parameter int ENTRIES = 16
) (
	input logic        clk,
	input logic        arst_n,
	rkt_chan_if.sink   req,
	rkt_chan_if.source rsp,
	rkt_chan_if.sink   cfg
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// state and control
	rkt_pkg::rkt_state_t state_q, state_d;
	logic                  load_item;
	logic                  scan_rd;
	logic                  do_write;
	logic                  resp_load;
	logic                  clear_tbl;

	// config registers
	logic [62:0] epoch_q;
	logic [31:0] grace_q;

	// latched item
	logic [1:0]          act_q;
	rkt_pkg::rkt_key_t   key_q;
	logic [63:0]         now_q;

	// key of the incoming item, normalized
	logic [rkt_pkg::CALL_W-1:0] call_clean;
	logic [rkt_pkg::BAND_W-1:0] band_clean;
	logic                       call_empty;
	logic                       clock_ok;

	// table bookkeeping
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   cnt_q;

	// compare stage
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	rkt_pkg::rkt_entry_t   rd_entry;
	rkt_pkg::rkt_entry_t   wr_entry;
	rkt_pkg::rkt_cmp_t     cmp;
	logic                  found_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic                  hit_q;

	// output register
	logic rsp_valid_q;
	logic rsp_hit_q;

	assign call_clean = rkt_pkg::clean_call({req.data.call_high, req.data.call_low});
	assign band_clean = rkt_pkg::clean_band(req.data.band_code);
	assign call_empty = (req.data.call_high[63:56] == 8'd0);
	// negative time counts as unset
	assign clock_ok   = !req.data.now_time[63] && (req.data.now_time[62:0] >= epoch_q);

	// configuration port, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= rkt_pkg::EPOCH_MIN_RST;
			grace_q <= rkt_pkg::GRACE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				rkt_pkg::CFG_EPOCH_MIN: epoch_q <= cfg.data.value[62:0];
				rkt_pkg::CFG_GRACE:     grace_q <= cfg.data.value[31:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_item = 1'b0;
		scan_rd   = 1'b0;
		do_write  = 1'b0;
		resp_load = 1'b0;
		clear_tbl = 1'b0;
		unique case (state_q)
			rkt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					load_item = 1'b1;
					state_d   = rkt_pkg::ST_FIN;
					if (req.data.action == rkt_pkg::ACT_CLEAR) begin
						clear_tbl = 1'b1;
					end else if (req.data.action == rkt_pkg::ACT_NOTE && !call_empty) begin
						state_d = rkt_pkg::ST_SCAN;
					end else if (req.data.action == rkt_pkg::ACT_QUERY && !call_empty
						&& clock_ok) begin
						state_d = rkt_pkg::ST_SCAN;
					end
				end
			end
			rkt_pkg::ST_SCAN: begin
				scan_rd = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = rkt_pkg::ST_DRAIN;
				end
			end
			rkt_pkg::ST_DRAIN: begin
				// last entry is compared on this cycle
				state_d = (act_q == rkt_pkg::ACT_NOTE) ? rkt_pkg::ST_WRITE : rkt_pkg::ST_FIN;
			end
			rkt_pkg::ST_WRITE: begin
				do_write = 1'b1;
				state_d  = rkt_pkg::ST_FIN;
			end
			rkt_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					resp_load = 1'b1;
					state_d   = rkt_pkg::ST_IDLE;
				end
			end
			default: state_d = rkt_pkg::ST_IDLE;
		endcase
	end

	// item latch, payload only
	always_ff @(posedge clk) begin
		if (load_item) begin
			act_q         <= req.data.action;
			key_q.call_high <= call_clean[rkt_pkg::CALL_W-1 -: 64];
			key_q.call_low  <= call_clean[rkt_pkg::CALL_W-65:0];
			key_q.band      <= band_clean;
			now_q         <= req.data.now_time;
		end
	end

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_item) begin
			cnt_q <= '0;
		end else if (scan_rd && cnt_q != LAST_IDX) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// entry memory: key and time stamp per entry
	assign wr_entry.key   = key_q;
	assign wr_entry.stamp = now_q;

	rkt_ram #(
		.WIDTH ($bits(rkt_pkg::rkt_entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (found_q ? match_idx_q : head_q),
		.wr_data (wr_entry),
		.rd_en   (scan_rd),
		.rd_addr (cnt_q),
		.rd_data (rd_entry)
	);

	// compare stage tracks which entry the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			idx_s1 <= cnt_q;
		end
	end

	rkt_cmp_unit u_cmp (
		.entry       (rd_entry),
		.entry_valid (valid_q[idx_s1]),
		.key         (key_q),
		.now_time    (now_q),
		.grace       (grace_q),
		.result      (cmp)
	);

	// first matching entry for notes, any recent match for queries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
		end else if (load_item) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
		end else if (rd_vld_s1 && cmp.key_match) begin
			found_q <= 1'b1;
			if (cmp.recent) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && cmp.key_match && !found_q) begin
			match_idx_q <= idx_s1;
		end
	end

	// valid bits and ring head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= '0;
		end else if (clear_tbl) begin
			valid_q <= '0;
			head_q  <= '0;
		end else if (do_write && !found_q) begin
			valid_q[head_q] <= 1'b1;
			head_q          <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (resp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			rsp_hit_q <= (act_q == rkt_pkg::ACT_QUERY) && hit_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.data.worked_hit = rsp_hit_q;

`ifndef SYNTHESIS
	// read data is only compared in the cycle after a scan read
	a_s1_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == rkt_pkg::ST_SCAN))
		else $error("compare stage active without a scan read");

	// the ring head stays inside the table
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_IDX)
		else $error("ring head out of range");

	// a clear empties the table on the next cycle
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.action == rkt_pkg::ACT_CLEAR)
		|=> (valid_q == '0 && head_q == '0))
		else $error("table not empty after clear");

	// a table write happens only after the full scan
	a_write_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> $past(state_q == rkt_pkg::ST_DRAIN))
		else $error("table write without a completed scan");
`endif

endmodule
